// File: hw/rtl/arpc_pkg.sv
// shared types and constants of the arp cache block
package arpc_pkg;

  // cache geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // field widths
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int LEN_W     = 11;
  localparam int HALF_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;

  // packet checks
  localparam logic [LEN_W-1:0]  MIN_ARP_LEN = LEN_W'(28);
  localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
  localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
  localparam logic [HALF_W-1:0] OP_REQUEST  = 16'h0001;

  // operation codes
  localparam logic FUNC_LEARN   = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(1);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FINISH
  } arpc_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted transaction
    logic check;     // packet checks and own address compare
    logic scan;      // advance the entry scan
    logic hit;       // act on the matching entry
    logic miss;      // scan ran off the end
    logic out_load;  // move the result into the output register
  } arpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;     // result known without a scan
    logic match;     // compared entry matches
    logic last;      // compared entry is the last one
    logic out_free;  // output register can take a result
  } arpc_stat_t;

endpackage

// File: hw/rtl/arpc_ctrl.sv
// controller state machine of the arp cache block
module arpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  arpc_pkg::arpc_stat_t stat_i,
  output arpc_pkg::arpc_cmd_t  cmd_o
);
  import arpc_pkg::*;

  arpc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.early ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.match || stat_i.last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.hit  = stat_i.match;
        cmd_o.miss = !stat_i.match && stat_i.last;
      end
      ST_FINISH: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/arpc_dp.sv
// datapath of the arp cache block: item registers, entry store, result
module arpc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [arpc_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // input item
  input  logic                               func_i,
  input  logic [arpc_pkg::LEN_W-1:0]         packet_length_i,
  input  logic [arpc_pkg::HALF_W-1:0]        hw_type_i,
  input  logic [arpc_pkg::HALF_W-1:0]        proto_type_i,
  input  logic [arpc_pkg::HALF_W-1:0]        arp_opcode_i,
  input  logic [arpc_pkg::IP_W-1:0]          src_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]         src_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]          dst_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]          query_ip_i,
  // control
  input  arpc_pkg::arpc_cmd_t                cmd_i,
  output arpc_pkg::arpc_stat_t               stat_o,
  // result
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               dropped_o,
  output logic                               hit_o,
  output logic [arpc_pkg::MAC_W-1:0]         resolved_mac_o,
  output logic                               send_request_o,
  output logic                               send_reply_o,
  output logic [arpc_pkg::IP_W-1:0]          reply_ip_o,
  output logic [arpc_pkg::MAC_W-1:0]         reply_mac_o
);
  import arpc_pkg::*;

  // configuration registers
  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_OWN_IP)  own_ip_q  <= cfg_data_i[IP_W-1:0];
      if (cfg_index_i == CFG_OWN_MAC) own_mac_q <= cfg_data_i[MAC_W-1:0];
    end
  end

  // captured transaction
  logic             func_q;
  logic             bad_q;
  logic             op_req_q;
  logic [IP_W-1:0]  key_q;
  logic [IP_W-1:0]  tip_q;
  logic [MAC_W-1:0] smac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      bad_q    <= (packet_length_i < MIN_ARP_LEN) || (hw_type_i != HW_ETHERNET) ||
                  (proto_type_i != PROTO_IPV4);
      op_req_q <= (arp_opcode_i == OP_REQUEST);
      key_q    <= (func_i == FUNC_RESOLVE) ? query_ip_i : src_ip_i;
      tip_q    <= dst_ip_i;
      smac_q   <= src_mac_i;
    end
  end

  // scan counters: read address and the index of the registered read data
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] cmp_idx_q;

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.load) begin
      rd_idx_d = '0;
    end else if ((cmd_i.check || cmd_i.scan) && (rd_idx_q != LAST_IDX)) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
    end else begin
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= rd_idx_q;
    end
  end

  // entry store with registered read
  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];
  logic [IP_W-1:0]  rd_ip_q;
  logic [MAC_W-1:0] rd_mac_q;
  logic             learn_we;

  assign learn_we = cmd_i.hit && (func_q == FUNC_LEARN);

  always_ff @(posedge clk_i) begin
    if (learn_we) begin
      ip_mem[cmp_idx_q]  <= key_q;
      mac_mem[cmp_idx_q] <= smac_q;
    end
    rd_ip_q  <= ip_mem[rd_idx_q];
    rd_mac_q <= mac_mem[rd_idx_q];
  end

  // valid bits, cleared at reset
  logic [ENTRIES-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (learn_we) begin
      valid_q[cmp_idx_q] <= 1'b1;
    end
  end

  // entry compare: learn takes a free or matching slot, resolve a valid match
  logic cur_valid;
  logic ip_eq;
  assign cur_valid = valid_q[cmp_idx_q];
  assign ip_eq     = (rd_ip_q == key_q);

  // output register
  logic             out_valid_q;
  logic             out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // status
  always_comb begin
    stat_o.early    = (func_q == FUNC_RESOLVE) ? (key_q == own_ip_q) : bad_q;
    stat_o.match    = (func_q == FUNC_RESOLVE) ? (cur_valid && ip_eq)
                                               : (!cur_valid || ip_eq);
    stat_o.last     = (cmp_idx_q == LAST_IDX);
    stat_o.out_free = out_free;
  end

  // staged result
  logic             r_dropped_q;
  logic             r_hit_q;
  logic [MAC_W-1:0] r_mac_q;
  logic             r_req_q;
  logic             r_reply_q;
  logic             reply_now;

  assign reply_now = (func_q == FUNC_LEARN) && !bad_q && op_req_q && (tip_q == own_ip_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_dropped_q <= 1'b0;
      r_hit_q     <= 1'b0;
      r_mac_q     <= '0;
      r_req_q     <= 1'b0;
      r_reply_q   <= 1'b0;
    end else if (cmd_i.check) begin
      r_dropped_q <= (func_q == FUNC_LEARN) && bad_q;
      r_reply_q   <= reply_now;
      if ((func_q == FUNC_RESOLVE) && (key_q == own_ip_q)) begin
        r_hit_q <= 1'b1;
        r_mac_q <= own_mac_q;
      end
    end else if (cmd_i.hit && (func_q == FUNC_RESOLVE)) begin
      r_hit_q <= 1'b1;
      r_mac_q <= rd_mac_q;
    end else if (cmd_i.miss && (func_q == FUNC_RESOLVE)) begin
      r_req_q <= 1'b1;
    end
  end

  // result transaction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dropped_o      <= r_dropped_q;
      hit_o          <= r_hit_q;
      resolved_mac_o <= r_mac_q;
      send_request_o <= r_req_q;
      send_reply_o   <= r_reply_q;
      reply_ip_o     <= r_reply_q ? key_q  : '0;
      reply_mac_o    <= r_reply_q ? smac_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/arp_cache_learn_resolve.sv
// top level of the arp cache block: controller, datapath and ports
//
// A fixed cache of 16 ip-to-mac entries with two operations on one input
// channel. func 0 learns from a parsed arp packet: bad length or type gives
// dropped, otherwise the sender goes into the first free or matching entry
// (a full cache without a match stays as is), and a request for the own ip
// gives send_reply with the requester's addresses. func 1 resolves query_ip:
// own mac for own ip, the cached mac on a hit, else send_request.
// Input and output use valid/stall; the configuration port (own_ip at index
// 0, own_mac at index 1) uses valid/ready and is always ready.
// An item is captured, then checked and, unless no scan is needed (dropped
// packet, own ip), compared against the 16 entries in order until a match
// or the last one; its result then moves into the output register. The
// entry store is scanned one entry per cycle through its single registered
// read port; one item is in work at a time, and the next one is taken the
// cycle after the result has moved into the output register, even while
// that result is still stalled. Reset clears the configuration and all
// valid bits at once; no clearing pass. A stalled result holds until taken
// and holds the next result back.
module arp_cache_learn_resolve (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arpc_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [arpc_pkg::LEN_W-1:0]       packet_length_i,
  input  logic [arpc_pkg::HALF_W-1:0]      hw_type_i,
  input  logic [arpc_pkg::HALF_W-1:0]      proto_type_i,
  input  logic [arpc_pkg::HALF_W-1:0]      arp_opcode_i,
  input  logic [arpc_pkg::IP_W-1:0]        src_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]       src_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]        dst_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]        query_ip_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             dropped_o,
  output logic                             hit_o,
  output logic [arpc_pkg::MAC_W-1:0]       resolved_mac_o,
  output logic                             send_request_o,
  output logic                             send_reply_o,
  output logic [arpc_pkg::IP_W-1:0]        reply_ip_o,
  output logic [arpc_pkg::MAC_W-1:0]       reply_mac_o
);
  import arpc_pkg::*;

  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  arpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .packet_length_i (packet_length_i),
    .hw_type_i       (hw_type_i),
    .proto_type_i    (proto_type_i),
    .arp_opcode_i    (arp_opcode_i),
    .src_ip_i        (src_ip_i),
    .src_mac_i       (src_mac_i),
    .dst_ip_i        (dst_ip_i),
    .query_ip_i      (query_ip_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dropped_o       (dropped_o),
    .hit_o           (hit_o),
    .resolved_mac_o  (resolved_mac_o),
    .send_request_o  (send_request_o),
    .send_reply_o    (send_reply_o),
    .reply_ip_o      (reply_ip_o),
    .reply_mac_o     (reply_mac_o)
  );

endmodule
